@@ design/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and key codes of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

    // Key codes
    localparam logic [7:0] KEY_DEL    = 8'h7F;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_KILL   = 8'h15;
    localparam logic [7:0] KEY_CLEAR  = 8'h0C;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_DOLLAR = 8'h24;

    // Result destinations
    localparam logic [1:0] DEST_ECHO    = 2'd0;
    localparam logic [1:0] DEST_DELIVER = 2'd1;
    localparam logic [1:0] DEST_CLEAR   = 2'd2;

    localparam int unsigned CFG_W   = 5;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned TDATA_W = 24;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Command queue geometry
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_DELIVER,
        CMD_ERASE,
        CMD_KILL,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cle_cmd_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERASE,
        ST_CLEAR
    } back_state_t;

endpackage

@@ design/cle_front.sv @@
// ----------------------------------------------------------------------------
// cle_front
// Accepts received bytes and classifies them into editing commands.
// ----------------------------------------------------------------------------
module cle_front (
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  cle_pkg::q_status_t q_stat,
    output logic              push,
    output cle_pkg::cle_cmd_t push_cmd
);
    import cle_pkg::*;

    assign s_axis_tready = q_stat.not_full;
    assign push          = s_axis_tvalid && q_stat.not_full;

    always_comb begin
        push_cmd.data = s_axis_tdata;
        unique case (s_axis_tdata)
            KEY_DEL, KEY_BS: begin
                push_cmd.kind = CMD_ERASE;
            end
            KEY_KILL: begin
                push_cmd.kind = CMD_KILL;
            end
            KEY_CLEAR: begin
                push_cmd.kind = CMD_CLEAR;
            end
            KEY_CR: begin
                // carriage return goes to the reader as line feed
                push_cmd.kind = CMD_DELIVER;
                push_cmd.data = KEY_LF;
            end
            default: begin
                push_cmd.kind = CMD_DELIVER;
            end
        endcase
    end

endmodule

@@ design/cle_queue.sv @@
// ----------------------------------------------------------------------------
// cle_queue
// Short command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module cle_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cle_pkg::cle_cmd_t  push_cmd,
    input  logic               pop,
    output cle_pkg::cle_cmd_t  pop_cmd,
    output cle_pkg::q_status_t q_stat
);
    import cle_pkg::*;

    cle_cmd_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0]  count_reg, count_next;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.not_full  = (count_reg != QCOUNT_W'(QDEPTH));
    assign pop_cmd          = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCOUNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCOUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/cle_back.sv @@
// ----------------------------------------------------------------------------
// cle_back
// Sequencer: keeps the line count and emits echo, delivery and clear requests.
// ----------------------------------------------------------------------------
module cle_back #(
    parameter int unsigned LINE_MAX = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [cle_pkg::CFG_W-1:0]    cfg_wr_data,
    input  cle_pkg::q_status_t           q_stat,
    input  cle_pkg::cle_cmd_t            pop_cmd,
    output logic                         pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [cle_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import cle_pkg::*;

    localparam logic [COUNT_W-1:0] LineMaxC = COUNT_W'(LINE_MAX);

    back_state_t          state_reg, state_next;
    logic [1:0]           step_reg, step_next;
    logic                 kill_reg, kill_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CFG_W-1:0]     limit_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_dest_reg, out_dest_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic [POS_W-1:0]     out_pos_reg, out_pos_next;
    logic                 out_done_reg, out_done_next;
    logic [COUNT_W-1:0]   out_len_reg, out_len_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic [COUNT_W-1:0]   limit_eff;
    logic [COUNT_W-1:0]   count_inc;
    logic                 line_end;

    always_comb begin
        if (COUNT_W'(limit_reg) > LineMaxC) begin
            limit_eff = LineMaxC;
        end else if (limit_reg == '0) begin
            limit_eff = COUNT_W'(1);
        end else begin
            limit_eff = COUNT_W'(limit_reg);
        end
    end

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign count_inc = count_reg + COUNT_W'(1);
    assign line_end  = (pop_cmd.data == KEY_LF) || (count_inc >= limit_eff);

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        kill_next      = kill_reg;
        count_next     = count_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_dest_next  = out_dest_reg;
        out_data_next  = out_data_reg;
        out_pos_next   = out_pos_reg;
        out_done_next  = out_done_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_stat.not_empty && out_free) begin
                    pop       = 1'b1;
                    step_next = 2'd0;
                    unique case (pop_cmd.kind)
                        CMD_DELIVER: begin
                            out_valid_next = 1'b1;
                            out_dest_next  = DEST_DELIVER;
                            out_data_next  = pop_cmd.data;
                            out_pos_next   = count_reg[POS_W-1:0];
                            out_done_next  = line_end;
                            out_len_next   = line_end ? count_inc : '0;
                            out_last_next  = 1'b1;
                            count_next     = line_end ? '0 : count_inc;
                        end
                        CMD_ERASE, CMD_KILL: begin
                            // nothing to erase on an empty line: drop the request
                            if (count_reg != '0) begin
                                state_next = ST_ERASE;
                                kill_next  = (pop_cmd.kind == CMD_KILL);
                            end
                        end
                        CMD_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ERASE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_dest_next  = DEST_ECHO;
                    out_data_next  = (step_reg == 2'd1) ? KEY_SPACE : KEY_BS;
                    out_pos_next   = '0;
                    out_done_next  = 1'b0;
                    out_len_next   = '0;
                    out_last_next  = (step_reg == 2'd2) &&
                                     (!kill_reg || count_reg == COUNT_W'(1));
                    if (step_reg == 2'd2) begin
                        count_next = count_reg - COUNT_W'(1);
                        step_next  = 2'd0;
                        if (out_last_next) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            ST_CLEAR: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = '0;
                    out_done_next  = 1'b0;
                    out_len_next   = '0;
                    out_last_next  = (step_reg == 2'd2);
                    case (step_reg)
                        2'd0: begin
                            out_dest_next = DEST_CLEAR;
                            out_data_next = 8'h00;
                        end
                        2'd1: begin
                            out_dest_next = DEST_ECHO;
                            out_data_next = KEY_DOLLAR;
                        end
                        default: begin
                            out_dest_next = DEST_ECHO;
                            out_data_next = KEY_SPACE;
                        end
                    endcase
                    if (step_reg == 2'd2) begin
                        step_next  = 2'd0;
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            kill_reg      <= 1'b0;
            count_reg     <= '0;
            limit_reg     <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            kill_reg      <= kill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_dest_reg <= out_dest_next;
        out_data_reg <= out_data_next;
        out_pos_reg  <= out_pos_next;
        out_done_reg <= out_done_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_dest_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'b0, out_len_reg, out_done_reg, out_pos_reg, out_data_reg};

endmodule

@@ design/console_line_editor.sv @@
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical-mode line editing for received console bytes.
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel and land, classified, in a two-entry
// command queue; the sequencer behind it emits at most one result per cycle
// through an output register while m_axis is ready. An ordinary byte (or
// carriage return, delivered as line feed) gives one delivery. Backspace or
// delete erases one character and Ctrl+U every character of the line,
// echoing backspace, space, backspace per character; on an empty line they
// give nothing. Ctrl+L gives a clear request, then '$' and space. The
// sequencer's one-result-per-cycle output sets the rate; a stalled m_axis
// side holds the sequencer while the queue keeps taking bytes until it is
// full. A line completes on line feed or when the count reaches
// cfg_wr_data (saturated to LINE_MAX, zero taken as one).
// ----------------------------------------------------------------------------
module console_line_editor #(
    parameter int unsigned LINE_MAX = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [cle_pkg::CFG_W-1:0]    cfg_wr_data,   // max_read_length
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] data_byte, [11:8] position, [12] line_done, [17:13] line_length
    output logic [cle_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,  // [1:0] dest
    output logic                         m_axis_tlast
);
    import cle_pkg::*;

    q_status_t q_stat;
    logic      push;
    logic      pop;
    cle_cmd_t  push_cmd;
    cle_cmd_t  pop_cmd;

    cle_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_stat        (q_stat),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    cle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    cle_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_stat        (q_stat),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
